// ===== rtl/core/div64_pkg.sv =====
// shared types and constants for the pipelined 64-bit divider
// no dependencies; imported by every module of the divider
package div64_pkg;

   localparam int WIDTH = 64;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_DIV_ZERO = 2'd1,
      STATUS_OVERFLOW = 2'd2
   } status_type;

   // partial remainder, dividend bits turning into quotient bits, divisor, sign fixups
   typedef struct packed {
      logic [WIDTH-1:0] rem;
      logic [WIDTH-1:0] num;
      logic [WIDTH-1:0] den;
      logic             neg_q;
      logic             neg_r;
      status_type       status;
   } stage_type;

   typedef struct packed {
      logic [WIDTH-1:0] quotient;
      logic [WIDTH-1:0] remainder_out;
      status_type       status;
   } result_type;

endpackage

// ===== rtl/core/div64_prep.sv =====
// input stage: error checks and operand magnitudes for the divider chain
// depends on div64_pkg
module div64_prep
   import div64_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             enable,
   input  logic             in_valid,
   input  logic             signed_mode,
   input  logic [WIDTH-1:0] dividend,
   input  logic [WIDTH-1:0] divisor,
   output logic             out_valid,
   output stage_type        out_stage
);

   localparam logic [WIDTH-1:0] SignBit = {1'b1, {(WIDTH-1){1'b0}}};

   logic      valid_ff;
   stage_type stage_ff;
   stage_type stage_in;
   logic      a_neg;
   logic      b_neg;

   always_comb begin
      a_neg = signed_mode & dividend[WIDTH-1];
      b_neg = signed_mode & divisor[WIDTH-1];
      stage_in.rem   = '0;
      stage_in.num   = a_neg ? (~dividend + {{(WIDTH-1){1'b0}}, 1'b1}) : dividend;
      stage_in.den   = b_neg ? (~divisor + {{(WIDTH-1){1'b0}}, 1'b1}) : divisor;
      stage_in.neg_q = a_neg ^ b_neg;
      stage_in.neg_r = a_neg;
      if (divisor == '0) begin
         stage_in.status = STATUS_DIV_ZERO;
      end else if (signed_mode && dividend == SignBit && divisor == '1) begin
         stage_in.status = STATUS_OVERFLOW;
      end else begin
         stage_in.status = STATUS_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         stage_ff <= stage_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_stage = stage_ff;

endmodule

// ===== rtl/core/div64_cell.sv =====
// one restoring division step: shift, trial subtract, keep or restore
// depends on div64_pkg
module div64_cell
   import div64_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      enable,
   input  logic      in_valid,
   input  stage_type in_stage,
   output logic      out_valid,
   output stage_type out_stage
);

   logic             valid_ff;
   stage_type        stage_ff;
   stage_type        stage_in;
   logic [WIDTH-1:0] shifted;
   logic [WIDTH:0]   diff;
   logic             take;

   always_comb begin
      shifted = {in_stage.rem[WIDTH-2:0], in_stage.num[WIDTH-1]};
      diff    = {1'b0, shifted} - {1'b0, in_stage.den};
      // bit shifted out of the top means the remainder already exceeds the divisor
      take    = in_stage.rem[WIDTH-1] | ~diff[WIDTH];
      stage_in     = in_stage;
      stage_in.rem = take ? diff[WIDTH-1:0] : shifted;
      stage_in.num = {in_stage.num[WIDTH-2:0], take};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         stage_ff <= stage_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_stage = stage_ff;

endmodule

// ===== rtl/core/div64_post.sv =====
// sign fixup of quotient and remainder, zeroing on error
// depends on div64_pkg
module div64_post
   import div64_pkg::*;
(
   input  stage_type  in_stage,
   output result_type result
);

   always_comb begin
      result.status = in_stage.status;
      if (in_stage.status != STATUS_OK) begin
         result.quotient      = '0;
         result.remainder_out = '0;
      end else begin
         result.quotient      = in_stage.neg_q ? (~in_stage.num + {{(WIDTH-1){1'b0}}, 1'b1})
                                               : in_stage.num;
         result.remainder_out = in_stage.neg_r ? (~in_stage.rem + {{(WIDTH-1){1'b0}}, 1'b1})
                                               : in_stage.rem;
      end
   end

endmodule

// ===== rtl/core/div64_skid.sv =====
// two-entry output queue that decouples the chain from result backpressure
// depends on div64_pkg
module div64_skid
   import div64_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  result_type push_data,
   output logic       room,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output result_type rsp_data
);

   result_type entry_ff [2];
   logic       wr_ptr_ff;
   logic       wr_ptr_in;
   logic       rd_ptr_ff;
   logic       rd_ptr_in;
   logic [1:0] count_ff;
   logic [1:0] count_in;
   logic       pop;

   always_comb begin
      pop       = rsp_tvalid & rsp_tready;
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign room       = (count_ff != 2'd2);
   assign rsp_tvalid = (count_ff != 2'd0);
   assign rsp_data   = entry_ff[rd_ptr_ff];

endmodule

// ===== rtl/core/divider_64bit_signed_unsigned_unit.sv =====
// top level of the pipelined signed/unsigned restoring divider
// depends on div64_pkg, div64_prep, div64_cell, div64_post, div64_skid
//
//   channel   dir   tdata                                  tuser
//   req_      in    dividend[63:0], divisor[127:64]        signed_mode
//   rsp_      out   quotient[63:0], remainder_out[127:64]  status[1:0]
//
// one item per cycle while the output queue has room; the path runs through the input stage,
// one cell per quotient bit and the output queue
// the chain moves as one and stops only while the two-entry output queue is full
// reset clears all valid bits and the queue; data registers are not reset
module divider_64bit_signed_unsigned_unit
   import div64_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [2*WIDTH-1:0] req_tdata,  // dividend, divisor
   input  logic             req_tuser,  // signed_mode
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [2*WIDTH-1:0] rsp_tdata,  // quotient, remainder_out
   output logic [1:0]       rsp_tuser   // status
);

   logic       advance;
   logic       valid [WIDTH+1];
   stage_type  stage [WIDTH+1];
   result_type result;
   result_type rsp_data;

   assign req_tready = advance;

   div64_prep u_prep (
      .clock       (clock),
      .reset       (reset),
      .enable      (advance),
      .in_valid    (req_tvalid),
      .signed_mode (req_tuser),
      .dividend    (req_tdata[WIDTH-1:0]),
      .divisor     (req_tdata[2*WIDTH-1:WIDTH]),
      .out_valid   (valid[0]),
      .out_stage   (stage[0])
   );

   // one cell per quotient bit, most significant first
   for (genvar i = 0; i < WIDTH; i++) begin : g_cell
      div64_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .enable    (advance),
         .in_valid  (valid[i]),
         .in_stage  (stage[i]),
         .out_valid (valid[i+1]),
         .out_stage (stage[i+1])
      );
   end

   div64_post u_post (
      .in_stage (stage[WIDTH]),
      .result   (result)
   );

   div64_skid u_skid (
      .clock      (clock),
      .reset      (reset),
      .push       (advance & valid[WIDTH]),
      .push_data  (result),
      .room       (advance),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_data   (rsp_data)
   );

   assign rsp_tdata = {rsp_data.remainder_out, rsp_data.quotient};
   assign rsp_tuser = rsp_data.status;

endmodule
